@@ rtl/core/priority_ready_queue_scheduler_assert.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PRQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PRQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/prq_pkg.sv @@
// Types and codes for the priority ready queue scheduler.
`default_nettype none

package prq_pkg;

	localparam int ACT_W  = 2;
	localparam int TASK_W = 5;
	localparam int LVL_W  = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_PICK   = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_DUP  = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_CHK,
		ST_ADD_LINK,
		ST_RM_CHK,
		ST_RM_HEAD,
		ST_RM_WALK,
		ST_PK_SCAN,
		ST_PK_HEAD,
		ST_PK_ROT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/prq_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module prq_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 5,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wa,
	input  wire logic [WIDTH-1:0] wd,
	input  wire logic [AW-1:0]    ra,
	output logic      [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[ra];
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

@@ rtl/core/priority_ready_queue_scheduler.sv @@
// Multilevel priority round-robin ready queue scheduler, linked lists in RAM.
// Steps from accept to done: add checks the task, then links it behind the tail if the level
// is not empty; remove checks, reads the head, then walks its list; pick scans the levels, reads the head, may rotate.
// One item at a time; set by the one-entry-per-cycle list walk and level scan.
// A new word is taken in the cycle that done is high; the receiver cannot stall.
// Reset clears all queues at once (valid bits in flops); no clearing pass is needed.
`default_nettype none

module priority_ready_queue_scheduler
	import prq_pkg::*;
#(
	parameter int NUM_LEVELS = 32,
	parameter int MAX_TASKS  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [TASK_W-1:0] task_id,
	input  wire logic [LVL_W-1:0]  priority_req,
	output logic                   done,
	output logic                   picked_valid,
	output logic [TASK_W-1:0]      picked_task,
	output logic [1:0]             status
);

	`include "priority_ready_queue_scheduler_assert.svh"

	localparam int TW = $clog2(MAX_TASKS);
	localparam int LW = $clog2(NUM_LEVELS);

	state_t state_q, state_d;

	logic [NUM_LEVELS-1:0] nonempty_q;
	logic [MAX_TASKS-1:0]  queued_q;
	logic [MAX_TASKS-1:0]  nv_q;

	logic [TW-1:0] t_q, cur_q, prev_q, cnt_q;
	logic [LW-1:0] lvl_q;
	logic          bad_q, has_prev_q;

	logic          done_q, picked_valid_q;
	logic [TW-1:0] picked_task_q;
	stat_t         status_q;

	logic [TW-1:0] head_rd, tail_rd, nt_rd;

	logic          head_we, tail_we, nt_we;
	logic [TW-1:0] head_wd, tail_wd, nt_wa, nt_wd, nt_ra;

	logic          fin, fin_valid;
	logic [TW-1:0] fin_task;
	stat_t         fin_status;

	logic          ne_set, ne_clr, q_set, q_clr;
	logic          nv_clr_en, nv_wr_en, nv_wr_val;
	logic [TW-1:0] nv_clr_idx, nv_wr_idx;
	logic          load_cur, walk_adv, lvl_adv;
	logic          accept, req_bad;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign req_bad = (int'(task_id) >= MAX_TASKS) || (int'(priority_req) >= NUM_LEVELS);

	prq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(TW)) u_head (
		.clk(clk), .we(head_we), .wa(lvl_q), .wd(head_wd), .ra(lvl_q), .rd(head_rd)
	);

	prq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(TW)) u_tail (
		.clk(clk), .we(tail_we), .wa(lvl_q), .wd(tail_wd), .ra(lvl_q), .rd(tail_rd)
	);

	prq_ram #(.DEPTH(MAX_TASKS), .WIDTH(TW)) u_next (
		.clk(clk), .we(nt_we), .wa(nt_wa), .wd(nt_wd), .ra(nt_ra), .rd(nt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		head_we    = 1'b0;
		head_wd    = t_q;
		tail_we    = 1'b0;
		tail_wd    = t_q;
		nt_we      = 1'b0;
		nt_wa      = tail_rd;
		nt_wd      = t_q;
		nt_ra      = cur_q;
		fin        = 1'b0;
		fin_valid  = 1'b0;
		fin_task   = '0;
		fin_status = STAT_MISS;
		ne_set     = 1'b0;
		ne_clr     = 1'b0;
		q_set      = 1'b0;
		q_clr      = 1'b0;
		nv_clr_en  = 1'b0;
		nv_clr_idx = t_q;
		nv_wr_en   = 1'b0;
		nv_wr_idx  = tail_rd;
		nv_wr_val  = 1'b1;
		load_cur   = 1'b0;
		walk_adv   = 1'b0;
		lvl_adv    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_ADD:    state_d = ST_ADD_CHK;
						ACT_REMOVE: state_d = ST_RM_CHK;
						ACT_PICK:   state_d = ST_PK_SCAN;
						default:    fin = 1'b1;
					endcase
				end
			end
			ST_ADD_CHK: begin
				state_d = ST_IDLE;
				fin     = 1'b1;
				if (bad_q) begin
					fin_status = STAT_MISS;
				end else if (queued_q[t_q]) begin
					fin_status = STAT_DUP;
				end else if (!nonempty_q[lvl_q]) begin
					head_we    = 1'b1;
					tail_we    = 1'b1;
					ne_set     = 1'b1;
					q_set      = 1'b1;
					nv_clr_en  = 1'b1;
					fin_status = STAT_DONE;
				end else begin
					fin     = 1'b0;
					state_d = ST_ADD_LINK;
				end
			end
			ST_ADD_LINK: begin
				// append behind the current tail
				nt_we      = 1'b1;
				nv_wr_en   = 1'b1;
				tail_we    = 1'b1;
				q_set      = 1'b1;
				nv_clr_en  = 1'b1;
				fin        = 1'b1;
				fin_status = STAT_DONE;
				state_d    = ST_IDLE;
			end
			ST_RM_CHK: begin
				if (bad_q || !nonempty_q[lvl_q]) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RM_HEAD;
				end
			end
			ST_RM_HEAD: begin
				nt_ra    = head_rd;
				load_cur = 1'b1;
				state_d  = ST_RM_WALK;
			end
			ST_RM_WALK: begin
				if (cur_q == t_q) begin
					// unlink the current entry
					if (has_prev_q) begin
						nt_we     = 1'b1;
						nt_wa     = prev_q;
						nt_wd     = nt_rd;
						nv_wr_en  = 1'b1;
						nv_wr_idx = prev_q;
						nv_wr_val = nv_q[cur_q];
						if (tail_rd == cur_q) begin
							tail_we = 1'b1;
							tail_wd = prev_q;
						end
					end else if (nv_q[cur_q]) begin
						head_we = 1'b1;
						head_wd = nt_rd;
					end else begin
						ne_clr = 1'b1;
					end
					nv_clr_en  = 1'b1;
					nv_clr_idx = cur_q;
					q_clr      = 1'b1;
					fin        = 1'b1;
					fin_status = STAT_DONE;
					state_d    = ST_IDLE;
				end else if (!nv_q[cur_q] || cnt_q == TW'(MAX_TASKS - 1)) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					// fetch the link of the following entry while advancing
					nt_ra    = nt_rd;
					walk_adv = 1'b1;
				end
			end
			ST_PK_SCAN: begin
				if (nonempty_q[lvl_q]) begin
					state_d = ST_PK_HEAD;
				end else if (lvl_q == LW'(NUM_LEVELS - 1)) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					lvl_adv = 1'b1;
				end
			end
			ST_PK_HEAD: begin
				nt_ra    = head_rd;
				load_cur = 1'b1;
				if (nv_q[head_rd]) begin
					state_d = ST_PK_ROT;
				end else begin
					fin        = 1'b1;
					fin_valid  = 1'b1;
					fin_task   = head_rd;
					fin_status = STAT_DONE;
					state_d    = ST_IDLE;
				end
			end
			ST_PK_ROT: begin
				// rotate the served head to the tail
				head_we    = 1'b1;
				head_wd    = nt_rd;
				nv_clr_en  = 1'b1;
				nv_clr_idx = cur_q;
				nt_we      = 1'b1;
				nt_wd      = cur_q;
				nv_wr_en   = 1'b1;
				tail_we    = 1'b1;
				tail_wd    = cur_q;
				fin        = 1'b1;
				fin_valid  = 1'b1;
				fin_task   = cur_q;
				fin_status = STAT_DONE;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			nonempty_q <= '0;
			queued_q   <= '0;
			nv_q       <= '0;
		end else begin
			done_q <= fin;
			if (ne_set) begin
				nonempty_q[lvl_q] <= 1'b1;
			end
			if (ne_clr) begin
				nonempty_q[lvl_q] <= 1'b0;
			end
			if (q_set) begin
				queued_q[t_q] <= 1'b1;
			end
			if (q_clr) begin
				queued_q[t_q] <= 1'b0;
			end
			if (nv_clr_en) begin
				nv_q[nv_clr_idx] <= 1'b0;
			end
			if (nv_wr_en) begin
				nv_q[nv_wr_idx] <= nv_wr_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q   <= TW'(task_id);
			lvl_q <= (action == ACT_PICK) ? '0 : LW'(priority_req);
			bad_q <= req_bad;
		end else if (lvl_adv) begin
			lvl_q <= lvl_q + LW'(1);
		end
		if (load_cur) begin
			cur_q      <= head_rd;
			has_prev_q <= 1'b0;
			cnt_q      <= '0;
		end else if (walk_adv) begin
			prev_q     <= cur_q;
			cur_q      <= nt_rd;
			has_prev_q <= 1'b1;
			cnt_q      <= cnt_q + TW'(1);
		end
		if (fin) begin
			picked_valid_q <= fin_valid;
			picked_task_q  <= fin_task;
			status_q       <= fin_status;
		end
	end

	assign done         = done_q;
	assign picked_valid = picked_valid_q;
	assign picked_task  = TASK_W'(picked_task_q);
	assign status       = status_q;

	`PRQ_ASSERT_IMP(a_pick_status, done && picked_valid, status == STAT_DONE,
		"picked word without done status")
	`PRQ_ASSERT_IMP(a_empty_task, done && !picked_valid, picked_task == '0,
		"nonzero task without a pick")
	`PRQ_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
	`PRQ_ASSERT_NXT(a_go_busy,
		accept && (action == ACT_ADD || action == ACT_REMOVE || action == ACT_PICK),
		busy, "valid action accepted but sequencer stayed idle")
	`PRQ_ASSERT_IMP(a_walk_start, state_q == ST_RM_WALK && !has_prev_q, cnt_q == '0,
		"walk step count moved without a predecessor")

endmodule

`default_nettype wire
